// ----- sv/etp_pkg.sv -----
`default_nettype none
package etp_pkg;

   localparam int TickWidth    = 32;
   localparam int CountWidth   = 16;
   localparam int WrapWidth    = 17;
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;
   localparam int DivSteps     = TickWidth;
   localparam int DivCntWidth  = $clog2(DivSteps + 1);

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_START  = 2'd1;
   localparam logic [1:0] CMD_STOP   = 2'd2;
   localparam logic [1:0] CMD_SAMPLE = 2'd3;

   // register index sits on the word-select bit of paddr
   localparam logic REG_TICKS_PER_WRAP = 1'b0;

   localparam logic [WrapWidth-1:0] TicksPerWrapReset = 17'h10000;

   typedef struct packed {
      logic [1:0]            command;
      logic [CountWidth-1:0] counter_value;
      logic [TickWidth-1:0]  epoch_count;
   } req_payload_type;

   typedef struct packed {
      logic [TickWidth-1:0]  current_ticks;
      logic [TickWidth-1:0]  average_ticks;
      logic [CountWidth-1:0] run_count;
      logic                  running;
   } rsp_payload_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage
`default_nettype wire

// ----- sv/etp_elapsed.sv -----
`default_nettype none
module etp_elapsed import etp_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  load,
   input  wire logic [WrapWidth-1:0]  ticks_per_wrap,
   input  wire logic [TickWidth-1:0]  start_epoch,
   input  wire logic [CountWidth-1:0] start_count,
   input  wire logic [CountWidth-1:0] counter_value,
   input  wire logic [TickWidth-1:0]  epoch_count,
   output logic      [TickWidth-1:0]  elapsed
);

   logic [TickWidth-1:0]           wraps;
   logic [TickWidth-1:0]           wraps_m1;
   logic [TickWidth+WrapWidth-1:0] prod_full;
   logic [TickWidth-1:0]           first;
   logic [TickWidth-1:0]           prod_in, prod_ff;
   logic [TickWidth-1:0]           partial_in, partial_ff;
   logic [TickWidth-1:0]           diff_in, diff_ff;
   logic                           several_in, several_ff;
   logic                           one_in, one_ff;

   always_comb begin
      wraps      = epoch_count - start_epoch;
      wraps_m1   = wraps - 32'd1;
      prod_full  = {{WrapWidth{1'b0}}, wraps_m1} * {{TickWidth{1'b0}}, ticks_per_wrap};
      prod_in    = prod_full[TickWidth-1:0];
      first      = {{(TickWidth-WrapWidth){1'b0}}, ticks_per_wrap}
                   - {{(TickWidth-CountWidth){1'b0}}, start_count};
      partial_in = first + {{(TickWidth-CountWidth){1'b0}}, counter_value};
      diff_in    = {{(TickWidth-CountWidth){1'b0}}, counter_value}
                   - {{(TickWidth-CountWidth){1'b0}}, start_count};
      several_in = wraps > 32'd1;
      one_in     = (wraps != '0) || (counter_value < start_count);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff    <= prod_in;
         partial_ff <= partial_in;
         diff_ff    <= diff_in;
         several_ff <= several_in;
         one_ff     <= one_in;
      end
   end

   always_comb begin
      if (several_ff) begin
         elapsed = prod_ff + partial_ff;
      end else if (one_ff) begin
         elapsed = partial_ff;
      end else begin
         elapsed = diff_ff;
      end
   end

endmodule
`default_nettype wire

// ----- sv/etp_divider.sv -----
`default_nettype none
module etp_divider import etp_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [TickWidth-1:0]  dividend,
   input  wire logic [CountWidth-1:0] divisor,
   output logic      [TickWidth-1:0]  quotient,
   output div_status_type             status
);

   logic [CountWidth-1:0]  rem_in, rem_ff;
   logic [TickWidth-1:0]   quo_in, quo_ff;
   logic [CountWidth-1:0]  dsr_in, dsr_ff;
   logic [DivCntWidth-1:0] cnt_in, cnt_ff;
   logic                   busy_in, busy_ff;
   logic                   done_in, done_ff;
   logic [CountWidth:0]    shifted;
   logic [CountWidth+1:0]  trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[TickWidth-1]};
      trial   = {1'b0, shifted} - {2'b00, dsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = DivCntWidth'(DivSteps);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // restoring step: keep the trial difference when it did not borrow
         if (!trial[CountWidth+1]) begin
            rem_in = trial[CountWidth-1:0];
         end else begin
            rem_in = shifted[CountWidth-1:0];
         end
         quo_in = {quo_ff[TickWidth-2:0], ~trial[CountWidth+1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DivCntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
`default_nettype wire

// ----- sv/elapsed_tick_profiler.sv -----
// Profiling stopwatch over a free-running 16-bit counter and its 32-bit overflow epoch.
// Each request beat (clear, start, stop or sample) yields one response beat carrying the
// current elapsed ticks (or the last run when idle), the average run length, the run count
// and the running flag. An item passes from acceptance to a loaded response through these steps:
// a multiply step for the wrap product, an update step, a divider launch, 32 steps
// of the bit-serial divider that forms total / run count, a step to see the divider
// finish, and the load of the response register. The block accepts one item at a time,
// so a new request beat is taken only after the previous item has loaded its response.
// A response waiting in the output register does not stop the next item being taken;
// that item then waits in its load step until the output register is free.
`default_nettype none
module elapsed_tick_profiler import etp_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire req_payload_type         req_payload,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output rsp_payload_type              rsp_payload,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [CsrDataWidth-1:0] csr_pwdata,
   output logic      [CsrDataWidth-1:0] csr_prdata,
   output logic                         csr_pready
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_MUL    = 6'b000010,
      ST_UPDATE = 6'b000100,
      ST_DIVGO  = 6'b001000,
      ST_DIV    = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type             state_in, state_ff;
   logic [WrapWidth-1:0]  tpw_in, tpw_ff;
   logic [TickWidth-1:0]  total_in, total_ff;
   logic [TickWidth-1:0]  last_in, last_ff;
   logic [CountWidth-1:0] runs_in, runs_ff;
   logic                  running_in, running_ff;
   logic [TickWidth-1:0]  start_epoch_in, start_epoch_ff;
   logic [CountWidth-1:0] start_count_in, start_count_ff;
   logic                  stop_in, stop_ff;
   logic [CountWidth-1:0] now_in, now_ff;
   logic [TickWidth-1:0]  epoch_in, epoch_ff;
   logic [TickWidth-1:0]  cur_in, cur_ff;
   logic                  rsp_valid_in, rsp_valid_ff;
   rsp_payload_type       rsp_in, rsp_ff;
   logic                  req_fire;
   logic                  csr_write;
   logic [TickWidth-1:0]  elapsed;
   logic [TickWidth-1:0]  quotient;
   div_status_type        div_status;

   etp_elapsed u_elapsed (
      .clock         (clock),
      .load          (state_ff == ST_MUL),
      .ticks_per_wrap(tpw_ff),
      .start_epoch   (start_epoch_ff),
      .start_count   (start_count_ff),
      .counter_value (now_ff),
      .epoch_count   (epoch_ff),
      .elapsed       (elapsed)
   );

   etp_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (state_ff == ST_DIVGO),
      .dividend(total_ff),
      .divisor (runs_ff),
      .quotient(quotient),
      .status  (div_status)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_TICKS_PER_WRAP)
                       ? {{(CsrDataWidth-WrapWidth){1'b0}}, tpw_ff} : '0;

   always_comb begin
      state_in       = state_ff;
      tpw_in         = tpw_ff;
      total_in       = total_ff;
      last_in        = last_ff;
      runs_in        = runs_ff;
      running_in     = running_ff;
      start_epoch_in = start_epoch_ff;
      start_count_in = start_count_ff;
      stop_in        = stop_ff;
      now_in         = now_ff;
      epoch_in       = epoch_ff;
      cur_in         = cur_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write && csr_paddr[2] == REG_TICKS_PER_WRAP) begin
         tpw_in = csr_pwdata[WrapWidth-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               now_in   = req_payload.counter_value;
               epoch_in = req_payload.epoch_count;
               stop_in  = 1'b0;
               case (req_payload.command)
                  CMD_CLEAR: begin
                     total_in   = '0;
                     last_in    = '0;
                     runs_in    = '0;
                     running_in = 1'b0;
                  end
                  CMD_START: begin
                     if (!running_ff) begin
                        last_in        = '0;
                        start_epoch_in = req_payload.epoch_count;
                        start_count_in = req_payload.counter_value;
                        running_in     = 1'b1;
                     end
                  end
                  CMD_STOP: begin
                     stop_in = running_ff;
                  end
                  default: begin
                  end
               endcase
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (stop_ff) begin
               last_in    = elapsed;
               total_in   = total_ff + elapsed;
               runs_in    = runs_ff + 1'b1;
               running_in = 1'b0;
            end
            cur_in   = (stop_ff || running_ff) ? elapsed : last_ff;
            state_in = ST_DIVGO;
         end
         ST_DIVGO: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_status.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.current_ticks = cur_ff;
               rsp_in.average_ticks = (runs_ff != '0) ? quotient : '0;
               rsp_in.run_count     = runs_ff;
               rsp_in.running       = running_ff;
               rsp_valid_in         = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         tpw_ff         <= TicksPerWrapReset;
         total_ff       <= '0;
         last_ff        <= '0;
         runs_ff        <= '0;
         running_ff     <= 1'b0;
         start_epoch_ff <= '0;
         start_count_ff <= '0;
         stop_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         tpw_ff         <= tpw_in;
         total_ff       <= total_in;
         last_ff        <= last_in;
         runs_ff        <= runs_in;
         running_ff     <= running_in;
         start_epoch_ff <= start_epoch_in;
         start_count_ff <= start_count_in;
         stop_ff        <= stop_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff   <= now_in;
      epoch_ff <= epoch_in;
      cur_ff   <= cur_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
module tb_top;
   import etp_pkg::*;

   localparam int CycleLimit   = 600000;
   localparam int SettleCycles = 48;
   localparam int LongHold     = 400;
   localparam int PrintCap     = 40;
   localparam int PhaseCount   = 6;
   localparam int PhaseItems   = 190;

   localparam logic [CsrAddrWidth-1:0] ADDR_TICKS_PER_WRAP = {REG_TICKS_PER_WRAP, 2'b00};
   localparam logic [CsrAddrWidth-1:0] ADDR_UNMAPPED       = 3'd4;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid   = 1'b0;
   logic                    req_ready;
   req_payload_type         req_payload = '0;
   logic                    rsp_valid;
   logic                    rsp_ready   = 1'b0;
   rsp_payload_type         rsp_payload;
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr   = '0;
   logic [CsrDataWidth-1:0] csr_pwdata  = '0;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   elapsed_tick_profiler dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   req_payload_type pending_items[$];
   rsp_payload_type expected_readings[$];

   int send_idle_pct  = 0;
   int stall_pct      = 0;
   bit sender_hold    = 1'b0;
   bit long_hold      = 1'b0;
   int hold_count     = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;
   int items_queued   = 0;

   // stopwatch state as the block should hold it
   logic [WrapWidth-1:0]  wrap_ticks = TicksPerWrapReset;
   logic [TickWidth-1:0]  sw_total = '0;
   logic [TickWidth-1:0]  sw_last = '0;
   logic [CountWidth-1:0] sw_runs = '0;
   logic                  sw_running = 1'b0;
   logic [TickWidth-1:0]  sw_start_epoch = '0;
   logic [CountWidth-1:0] sw_start_count = '0;

   function automatic logic [TickWidth-1:0] ticks_since_start(logic [CountWidth-1:0] now,
                                                              logic [TickWidth-1:0] epoch);
      logic [TickWidth-1:0] wraps;
      logic [TickWidth-1:0] period;
      logic [TickWidth-1:0] first;
      wraps  = epoch - sw_start_epoch;
      period = {{(TickWidth-WrapWidth){1'b0}}, wrap_ticks};
      first  = period - {16'd0, sw_start_count};
      if (wraps > 32'd1)
         return (wraps - 32'd1) * period + first + {16'd0, now};
      // a counter below its start value means a wrap not yet counted in the epoch
      if (wraps != 32'd0 || now < sw_start_count)
         return first + {16'd0, now};
      return {16'd0, now} - {16'd0, sw_start_count};
   endfunction

   task automatic predict_stopwatch(req_payload_type item);
      rsp_payload_type reading;
      case (item.command)
         CMD_CLEAR: begin
            sw_total   = '0;
            sw_last    = '0;
            sw_runs    = '0;
            sw_running = 1'b0;
         end
         CMD_START: begin
            if (!sw_running) begin
               sw_last        = '0;
               sw_start_epoch = item.epoch_count;
               sw_start_count = item.counter_value;
               sw_running     = 1'b1;
            end
         end
         CMD_STOP: begin
            if (sw_running) begin
               sw_last    = ticks_since_start(item.counter_value, item.epoch_count);
               sw_total   = sw_total + sw_last;
               sw_runs    = sw_runs + 16'd1;
               sw_running = 1'b0;
            end
         end
         default: ;
      endcase
      reading.current_ticks = sw_running ?
         ticks_since_start(item.counter_value, item.epoch_count) : sw_last;
      reading.average_ticks = (sw_runs != '0) ? sw_total / {16'd0, sw_runs} : '0;
      reading.run_count     = sw_runs;
      reading.running       = sw_running;
      expected_readings.push_back(reading);
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatch_count < PrintCap)
         $display("mismatch at cycle %0d: %s got %0h, want %0h", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_reading(rsp_payload_type got);
      rsp_payload_type want;
      if (expected_readings.size() == 0) begin
         report_mismatch("beat with nothing expected, current_ticks", got.current_ticks, '0);
         return;
      end
      want = expected_readings.pop_front();
      if (got.current_ticks !== want.current_ticks)
         report_mismatch("current_ticks", got.current_ticks, want.current_ticks);
      if (got.average_ticks !== want.average_ticks)
         report_mismatch("average_ticks", got.average_ticks, want.average_ticks);
      if (got.run_count !== want.run_count)
         report_mismatch("run_count", 32'(got.run_count), 32'(want.run_count));
      if (got.running !== want.running)
         report_mismatch("running", 32'(got.running), 32'(want.running));
   endtask

   // driver: offer the next pending beat, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            predict_stopwatch(req_payload);
         if (!req_valid || req_ready) begin
            if (pending_items.size() != 0 && !sender_hold &&
                $urandom_range(99) >= send_idle_pct) begin
               req_payload <= pending_items.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || !long_hold)
         hold_count <= 0;
      else if (hold_count < LongHold)
         hold_count <= hold_count + 1;
   end

   // monitor: check each accepted result beat
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_reading(rsp_payload);
         rsp_ready <= !(long_hold && hold_count < LongHold) &&
                      ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic csr_access(logic write, logic [CsrAddrWidth-1:0] addr, logic [31:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
   endtask

   task automatic csr_write(logic [CsrAddrWidth-1:0] addr, logic [31:0] data);
      csr_access(1'b1, addr, data);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_TICKS_PER_WRAP)
         wrap_ticks = data[WrapWidth-1:0];
   endtask

   task automatic csr_check(logic [CsrAddrWidth-1:0] addr, logic [31:0] want);
      csr_access(1'b0, addr, '0);
      // prdata is sampled at the edge that completes the access
      if (csr_prdata !== want)
         report_mismatch("register read", csr_prdata, want);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic queue_item(logic [1:0] command, logic [CountWidth-1:0] count,
                             logic [TickWidth-1:0] epoch);
      req_payload_type item;
      item.command       = command;
      item.counter_value = count;
      item.epoch_count   = epoch;
      pending_items.push_back(item);
      items_queued++;
   endtask

   function automatic logic [TickWidth-1:0] epoch_step();
      case ($urandom_range(9))
         0, 1, 2, 3: return 32'd0;
         4, 5:       return 32'd1;
         6, 7:       return $urandom_range(5, 2);
         8:          return $urandom;
         default:    return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h8000_0000;
      endcase
   endfunction

   // start, a few samples with the odd stray command, then stop
   task automatic queue_measurement();
      logic [CountWidth-1:0] first_count;
      logic [TickWidth-1:0]  first_epoch;
      int                    samples;
      first_count = 16'($urandom);
      first_epoch = $urandom;
      samples     = $urandom_range(3);
      queue_item(CMD_START, first_count, first_epoch);
      repeat (samples) begin
         case ($urandom_range(11))
            0:       queue_item(CMD_START, 16'($urandom), first_epoch + epoch_step());
            1:       queue_item(CMD_CLEAR, 16'($urandom), first_epoch + epoch_step());
            default: queue_item(CMD_SAMPLE, 16'($urandom), first_epoch + epoch_step());
         endcase
      end
      queue_item(CMD_STOP, 16'($urandom), first_epoch + epoch_step());
   endtask

   task automatic queue_random_items(int count);
      int goal;
      int pick;
      goal = items_queued + count;
      while (items_queued < goal) begin
         pick = $urandom_range(19);
         if (pick < 15)
            queue_measurement();
         else if (pick == 15)
            queue_item(CMD_CLEAR, 16'($urandom), $urandom);
         else
            queue_item(2'($urandom_range(3)), 16'($urandom), $urandom);
      end
   endtask

   task automatic wait_idle();
      while (pending_items.size() != 0 || req_valid || expected_readings.size() != 0)
         @(negedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   initial begin
      logic [31:0] wrap_setting [PhaseCount];
      int          idle_setting [PhaseCount];
      int          stall_setting [PhaseCount];
      int          phase;

      wrap_setting  = '{32'd1, 32'hFFFF_0000, 32'd0, 32'h0001_FFFF, $urandom, 32'd1000};
      idle_setting  = '{0, 53, 0, 32, 0, 53};
      stall_setting = '{0, 0, 53, 32, 53, 0};

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      csr_check(ADDR_TICKS_PER_WRAP, 32'(TicksPerWrapReset));

      queue_item(CMD_SAMPLE, 16'h0000, 32'h0000_0000);
      queue_item(CMD_STOP,   16'hFFFF, 32'hFFFF_FFFF);
      queue_item(CMD_START,  16'hFFFF, 32'hFFFF_FFFF);
      queue_item(CMD_START,  16'h0000, 32'h0000_0000);
      queue_item(CMD_SAMPLE, 16'h0000, 32'h0000_0000);
      queue_item(CMD_STOP,   16'hFFFF, 32'h0000_0005);
      queue_item(CMD_START,  16'd100,  32'd7);
      queue_item(CMD_SAMPLE, 16'd50,   32'd7);
      queue_item(CMD_STOP,   16'd50,   32'd7);
      queue_item(CMD_START,  16'd200,  32'd9);
      queue_item(CMD_SAMPLE, 16'd300,  32'd9);
      queue_item(CMD_STOP,   16'd300,  32'd9);
      queue_item(CMD_START,  16'h0000, 32'h0000_0000);
      queue_item(CMD_SAMPLE, 16'h0000, 32'h0000_0000);
      queue_item(CMD_STOP,   16'hFFFF, 32'hFFFF_FFFF);
      queue_item(CMD_START,  16'hAAAA, 32'h5555_5555);
      queue_item(CMD_STOP,   16'h5555, 32'hAAAA_AAAA);
      queue_item(CMD_CLEAR,  16'h1234, 32'h89AB_CDEF);
      queue_item(CMD_SAMPLE, 16'h4321, 32'h0000_0001);
      queue_item(CMD_STOP,   16'h4321, 32'h0000_0002);
      queue_item(CMD_START,  16'h8000, 32'h8000_0000);
      queue_item(CMD_CLEAR,  16'h9000, 32'h8000_0001);
      queue_item(CMD_STOP,   16'h9000, 32'h8000_0002);
      queue_item(CMD_START,  16'h7FFF, 32'h7FFF_FFFF);
      queue_item(CMD_STOP,   16'h8000, 32'h8000_0000);
      wait_idle();

      for (phase = 0; phase < PhaseCount; phase++) begin
         csr_write(ADDR_TICKS_PER_WRAP, wrap_setting[phase]);
         csr_check(ADDR_TICKS_PER_WRAP, 32'(wrap_ticks));
         if (phase == 2) begin
            csr_write(ADDR_UNMAPPED, $urandom);
            csr_check(ADDR_TICKS_PER_WRAP, 32'(wrap_ticks));
         end
         @(negedge clock);
         send_idle_pct = idle_setting[phase];
         stall_pct     = stall_setting[phase];
         queue_random_items(PhaseItems);
         if (phase == 0) begin
            // hold the result side off until the block backs up into its input
            long_hold = 1'b1;
            while (hold_count < LongHold) @(negedge clock);
            long_hold = 1'b0;
         end
         if (phase == 1) begin
            while (pending_items.size() > PhaseItems / 2) @(negedge clock);
            sender_hold = 1'b1;
            while (req_valid || expected_readings.size() != 0) @(negedge clock);
            repeat (SettleCycles) @(negedge clock);
            sender_hold = 1'b0;
         end
         wait_idle();
      end

      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
